// File: rtl/sip_pkg.sv
// ----------------------------------------------------------------------------
// sip_pkg
// Shared types and constants for the segment intersection pipeline.
// ----------------------------------------------------------------------------
package sip_pkg;

    localparam int COORD_BITS_DEF = 16;

    typedef logic signed [COORD_BITS_DEF-1:0] t_coord;

    typedef struct packed {
        t_coord      first_start_x;
        t_coord      first_start_y;
        t_coord      first_end_x;
        t_coord      first_end_y;
        t_coord      second_start_x;
        t_coord      second_start_y;
        t_coord      second_end_x;
        t_coord      second_end_y;
        logic [3:0]  include_mask;
    } t_sip_in;

    typedef struct packed {
        logic   hit;
        t_coord cross_x;
        t_coord cross_y;
    } t_sip_out;

    typedef struct packed {
        logic vld;
        logic hit;
    } t_sip_tag;

endpackage

// File: rtl/sip_orient.sv
// ----------------------------------------------------------------------------
// sip_orient
// Three stages: endpoint differences, cross-product terms, orientation signs,
// include-mask hit decision, crossing numerator and denominator.
// ----------------------------------------------------------------------------
module sip_orient #(
    parameter int COORD_BITS = sip_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  sip_pkg::t_sip_in                i_data,
    output sip_pkg::t_sip_tag               o_tag,
    output logic signed [2*COORD_BITS+2:0]  o_num,
    output logic signed [2*COORD_BITS+2:0]  o_den,
    output logic signed [COORD_BITS-1:0]    o_x1,
    output logic signed [COORD_BITS-1:0]    o_x2,
    output logic signed [COORD_BITS-1:0]    o_y1,
    output logic signed [COORD_BITS-1:0]    o_y2
);
    import sip_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int CW = 2 * COORD_BITS + 3;
    localparam int NC = 9;
    localparam int AI [8] = '{0, 0, 1, 1, 2, 2, 3, 3};
    localparam int BI [8] = '{1, 1, 0, 0, 3, 3, 2, 2};
    localparam int QI [8] = '{2, 3, 2, 3, 0, 1, 0, 1};

    logic signed [COORD_BITS-1:0] px [4];
    logic signed [COORD_BITS-1:0] py [4];

    logic signed [DW-1:0] n_lx [NC];
    logic signed [DW-1:0] n_ly [NC];
    logic signed [DW-1:0] n_u  [NC];
    logic signed [DW-1:0] n_v  [NC];
    logic signed [DW-1:0] r_lx [NC];
    logic signed [DW-1:0] r_ly [NC];
    logic signed [DW-1:0] r_u  [NC];
    logic signed [DW-1:0] r_v  [NC];
    logic signed [PW-1:0] r_m1 [NC];
    logic signed [PW-1:0] r_m2 [NC];
    logic signed [CW-1:0] c    [NC];

    logic        r_vld  [3];
    logic [3:0]  r_mask [2];
    logic signed [COORD_BITS-1:0] r_x1 [3];
    logic signed [COORD_BITS-1:0] r_x2 [3];
    logic signed [COORD_BITS-1:0] r_y1 [3];
    logic signed [COORD_BITS-1:0] r_y2 [3];
    logic        r_hit;
    logic signed [CW-1:0] r_num;
    logic signed [CW-1:0] r_den;

    logic [3:0] one, two;
    logic       ok1, ok2, n_hit;

    assign px[0] = COORD_BITS'(i_data.first_start_x);
    assign py[0] = COORD_BITS'(i_data.first_start_y);
    assign px[1] = COORD_BITS'(i_data.first_end_x);
    assign py[1] = COORD_BITS'(i_data.first_end_y);
    assign px[2] = COORD_BITS'(i_data.second_start_x);
    assign py[2] = COORD_BITS'(i_data.second_start_y);
    assign px[3] = COORD_BITS'(i_data.second_end_x);
    assign py[3] = COORD_BITS'(i_data.second_end_y);

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            n_lx[k] = DW'(px[BI[k]]) - DW'(px[AI[k]]);
            n_ly[k] = DW'(py[BI[k]]) - DW'(py[AI[k]]);
            n_u[k]  = DW'(px[QI[k]]) - DW'(px[AI[k]]);
            n_v[k]  = DW'(py[QI[k]]) - DW'(py[AI[k]]);
        end
        // denominator: first direction against second direction
        n_lx[8] = DW'(px[1]) - DW'(px[0]);
        n_ly[8] = DW'(py[1]) - DW'(py[0]);
        n_u[8]  = DW'(px[3]) - DW'(px[2]);
        n_v[8]  = DW'(py[3]) - DW'(py[2]);
    end

    always_comb begin
        for (int k = 0; k < NC; k++) begin
            c[k] = CW'(r_m1[k]) - CW'(r_m2[k]);
        end
        for (int t = 0; t < 4; t++) begin
            one[t] = (c[2*t] == '0) != (c[2*t+1] == '0);
            two[t] = (c[2*t] != '0) && (c[2*t+1] != '0)
                     && (c[2*t][CW-1] != c[2*t+1][CW-1]);
        end
        ok2   = (r_mask[1][3] && one[0] && one[1]) || (r_mask[1][2] && two[0] && two[1]);
        ok1   = (r_mask[1][1] && one[2] && one[3]) || (r_mask[1][0] && two[2] && two[3]);
        n_hit = ok1 && ok2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 3; s++) r_vld[s] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            r_vld[1] <= r_vld[0];
            r_vld[2] <= r_vld[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NC; k++) begin
                r_lx[k] <= n_lx[k];
                r_ly[k] <= n_ly[k];
                r_u[k]  <= n_u[k];
                r_v[k]  <= n_v[k];
                r_m1[k] <= PW'(r_lx[k]) * PW'(r_v[k]);
                r_m2[k] <= PW'(r_ly[k]) * PW'(r_u[k]);
            end
            r_mask[0] <= i_data.include_mask;
            r_mask[1] <= r_mask[0];
            r_x1[0]   <= px[0];
            r_y1[0]   <= py[0];
            r_x2[0]   <= px[1];
            r_y2[0]   <= py[1];
            for (int s = 1; s < 3; s++) begin
                r_x1[s] <= r_x1[s-1];
                r_y1[s] <= r_y1[s-1];
                r_x2[s] <= r_x2[s-1];
                r_y2[s] <= r_y2[s-1];
            end
            r_hit <= n_hit;
            r_num <= c[4];
            r_den <= c[8];
        end
    end

    assign o_tag.vld = r_vld[2];
    assign o_tag.hit = r_hit;
    assign o_num     = r_num;
    assign o_den     = r_den;
    assign o_x1      = r_x1[2];
    assign o_x2      = r_x2[2];
    assign o_y1      = r_y1[2];
    assign o_y2      = r_y2[2];

endmodule

// File: rtl/sip_coord.sv
// ----------------------------------------------------------------------------
// sip_coord
// One crossing coordinate: sign normalize, split multiply, pipelined restoring
// divide (one quotient bit per stage), floor-to-truncate correction.
// ----------------------------------------------------------------------------
module sip_coord #(
    parameter int COORD_BITS = sip_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  sip_pkg::t_sip_tag               i_tag,
    input  logic signed [2*COORD_BITS+2:0]  i_num,
    input  logic signed [2*COORD_BITS+2:0]  i_den,
    input  logic signed [COORD_BITS-1:0]    i_p1,
    input  logic signed [COORD_BITS-1:0]    i_p2,
    output sip_pkg::t_sip_tag               o_tag,
    output logic signed [COORD_BITS-1:0]    o_coord
);
    import sip_pkg::*;

    localparam int CW  = 2 * COORD_BITS + 3;
    localparam int DW  = COORD_BITS + 1;
    localparam int H   = COORD_BITS + 2;
    localparam int HW  = CW - H;
    localparam int PRW = CW + DW;
    localparam int QB  = DW;
    localparam int RW  = CW + 1;
    localparam int FW  = COORD_BITS + 3;

    // normalize stage
    logic signed [CW-1:0] nn;
    logic signed [DW-1:0] dv;
    logic [CW-1:0] n_dn, n_an;
    logic [DW-1:0] n_ad;
    logic [CW-1:0] rd_den, rd_an;
    logic [DW-1:0] rd_ad;
    logic          rd_neg, rd_dz;
    logic signed [COORD_BITS-1:0] rd_p1;
    t_sip_tag      rd_tag;

    // partial product stage
    logic [CW-1:0]     re_pl;
    logic [HW+DW-1:0]  re_ph;
    logic [CW-1:0]     re_den;
    logic              re_neg, re_dz;
    logic signed [COORD_BITS-1:0] re_p1;
    t_sip_tag          re_tag;

    logic [PRW-1:0] prod;

    // divider stages
    logic [CW-1:0] r_rem [QB+1];
    logic [QB-1:0] r_low [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic [CW-1:0] r_dd  [QB+1];
    logic          r_dn  [QB+1];
    logic          r_dz  [QB+1];
    logic signed [COORD_BITS-1:0] r_dp [QB+1];
    t_sip_tag      r_dt  [QB+1];

    logic [RW-1:0] t_rem [QB];
    logic          ge    [QB];
    logic [RW-1:0] n_rem [QB];

    logic signed [FW-1:0] qe, fl0, fl;
    logic          rnz;
    logic signed [COORD_BITS-1:0] n_out, r_out;
    t_sip_tag      r_otag;

    always_comb begin
        n_dn = i_den[CW-1] ? CW'(-i_den) : CW'(i_den);
        nn   = i_den[CW-1] ? -i_num : i_num;
        n_an = nn[CW-1] ? CW'(-nn) : CW'(nn);
        dv   = DW'(i_p2) - DW'(i_p1);
        n_ad = dv[DW-1] ? DW'(-dv) : DW'(dv);
    end

    assign prod = PRW'(re_pl) + (PRW'(re_ph) << H);

    always_comb begin
        for (int j = 0; j < QB; j++) begin
            t_rem[j] = {r_rem[j], r_low[j][QB-1]};
            ge[j]    = t_rem[j] >= {1'b0, r_dd[j]};
            n_rem[j] = ge[j] ? (t_rem[j] - {1'b0, r_dd[j]}) : t_rem[j];
        end
    end

    always_comb begin
        rnz = r_rem[QB] != '0;
        qe  = FW'($signed({1'b0, r_q[QB]}));
        fl0 = FW'(r_dp[QB]) + (r_dn[QB] ? -qe : qe)
              - FW'($signed({1'b0, r_dn[QB] && rnz}));
        // floor to truncate toward zero
        fl  = (fl0[FW-1] && rnz) ? fl0 + FW'(1) : fl0;
        n_out = (r_dt[QB].hit && !r_dz[QB]) ? fl[COORD_BITS-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_tag.vld <= 1'b0;
            re_tag.vld <= 1'b0;
            for (int j = 0; j <= QB; j++) r_dt[j].vld <= 1'b0;
            r_otag.vld <= 1'b0;
        end else if (i_en) begin
            rd_tag.vld <= i_tag.vld;
            re_tag.vld <= rd_tag.vld;
            r_dt[0].vld <= re_tag.vld;
            for (int j = 0; j < QB; j++) r_dt[j+1].vld <= r_dt[j].vld;
            r_otag.vld <= r_dt[QB].vld;

            rd_den     <= n_dn;
            rd_an      <= n_an;
            rd_ad      <= n_ad;
            rd_neg     <= nn[CW-1] ^ dv[DW-1];
            rd_dz      <= i_den == '0;
            rd_p1      <= i_p1;
            rd_tag.hit <= i_tag.hit;

            re_pl      <= CW'(rd_an[H-1:0]) * CW'(rd_ad);
            re_ph      <= (HW+DW)'(rd_an[CW-1:H]) * (HW+DW)'(rd_ad);
            re_den     <= rd_den;
            re_neg     <= rd_neg;
            re_dz      <= rd_dz;
            re_p1      <= rd_p1;
            re_tag.hit <= rd_tag.hit;

            r_rem[0]    <= prod[PRW-1:QB];
            r_low[0]    <= prod[QB-1:0];
            r_q[0]      <= '0;
            r_dd[0]     <= re_den;
            r_dn[0]     <= re_neg;
            r_dz[0]     <= re_dz;
            r_dp[0]     <= re_p1;
            r_dt[0].hit <= re_tag.hit;
            for (int j = 0; j < QB; j++) begin
                r_rem[j+1]    <= n_rem[j][CW-1:0];
                r_low[j+1]    <= r_low[j] << 1;
                r_q[j+1]      <= {r_q[j][QB-2:0], ge[j]};
                r_dd[j+1]     <= r_dd[j];
                r_dn[j+1]     <= r_dn[j];
                r_dz[j+1]     <= r_dz[j];
                r_dp[j+1]     <= r_dp[j];
                r_dt[j+1].hit <= r_dt[j].hit;
            end

            r_out      <= n_out;
            r_otag.hit <= r_dt[QB].hit;
        end
    end

    assign o_tag   = r_otag;
    assign o_coord = r_out;

endmodule

// File: rtl/segment_intersect_with_point.sv
// ----------------------------------------------------------------------------
// segment_intersect_with_point
// The divider takes one stage per quotient bit.
// Throughput: one transaction per cycle; a stall freezes the whole pipeline.
// Reset: synchronous, active low; clears the valid bits only, no clearing pass.
// ----------------------------------------------------------------------------
module segment_intersect_with_point #(
    parameter int COORD_BITS = sip_pkg::COORD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  sip_pkg::t_sip_in   i_data,
    output logic               o_stall,
    output logic               o_valid,
    output sip_pkg::t_sip_out  o_data,
    input  logic               i_stall
);
    import sip_pkg::*;

    localparam int CW = 2 * COORD_BITS + 3;

    logic en;
    t_sip_tag ot, tx, ty;
    logic signed [CW-1:0] num, den;
    logic signed [COORD_BITS-1:0] x1, x2, y1, y2, cx, cy;

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    sip_orient #(.COORD_BITS(COORD_BITS)) u_orient (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_tag   (ot),
        .o_num   (num),
        .o_den   (den),
        .o_x1    (x1),
        .o_x2    (x2),
        .o_y1    (y1),
        .o_y2    (y2)
    );

    sip_coord #(.COORD_BITS(COORD_BITS)) u_coord_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tag   (ot),
        .i_num   (num),
        .i_den   (den),
        .i_p1    (x1),
        .i_p2    (x2),
        .o_tag   (tx),
        .o_coord (cx)
    );

    sip_coord #(.COORD_BITS(COORD_BITS)) u_coord_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tag   (ot),
        .i_num   (num),
        .i_den   (den),
        .i_p1    (y1),
        .i_p2    (y2),
        .o_tag   (ty),
        .o_coord (cy)
    );

    assign o_valid        = tx.vld;
    assign o_data.hit     = tx.hit;
    assign o_data.cross_x = cx;
    assign o_data.cross_y = cy;

    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tx.vld == ty.vld && (!tx.vld || tx.hit == ty.hit))
        else $error("coordinate lanes out of step");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.hit |-> o_data.cross_x == '0 && o_data.cross_y == '0)
        else $error("nonzero point on a miss");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while the output can move");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

endmodule
